>>> rtl/core/word_position_ngram_counter_macros.svh
// Assertion macros shared by the word position n-gram counter RTL.
`ifndef WORD_POSITION_NGRAM_COUNTER_MACROS_SVH
`define WORD_POSITION_NGRAM_COUNTER_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define WNGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define WNGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wngc_pkg.sv
// Package with the shared types and constants of the word position n-gram counter.
package wngc_pkg;

  localparam int LETTERS_DEF    = 32;
  localparam int COUNT_BITS_DEF = 32;

  localparam int SYMBOL_BITS = 6;
  localparam int LETTER_BITS = 5;
  localparam int OUT_BITS    = 32;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] POS_START  = 2'd0;
  localparam logic [1:0] POS_MIDDLE = 2'd1;
  localparam logic [1:0] POS_END    = 2'd2;
  localparam logic [1:0] POS_NONE   = 2'd3;

  localparam logic [1:0] GRAM_UNI = 2'd1;
  localparam logic [1:0] GRAM_BI  = 2'd2;
  localparam logic [1:0] GRAM_TRI = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CLEAR
  } wngc_state_t;

  // Per-table request latched together with the row read.
  typedef struct packed {
    logic       bump;
    logic [1:0] pos;
  } wngc_ctl_t;

endpackage

>>> rtl/core/wngc_table.sv
// Counter table: one memory row per n-gram holding its start, middle and end counters.
module wngc_table import wngc_pkg::*; #(
  parameter int ADDR_BITS  = 5,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      issue,
  input  logic [ADDR_BITS-1:0]      addr,
  input  wngc_ctl_t                 ctl,
  input  logic                      commit,
  input  logic                      clr,
  input  logic [ADDR_BITS-1:0]      clr_addr,
  output logic [3*COUNT_BITS-1:0]   row
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [3*COUNT_BITS-1:0] mem [DEPTH];
  logic [ADDR_BITS-1:0]    addr_q;
  wngc_ctl_t               ctl_q;
  logic [3*COUNT_BITS-1:0] row_bumped;

  // Saturating increment of the selected counter in the row that was read.
  always_comb begin
    logic [COUNT_BITS-1:0] slot;
    row_bumped = row;
    for (int j = 0; j < 3; j++) begin
      slot = row[j*COUNT_BITS +: COUNT_BITS];
      if (ctl_q.pos == 2'(j) && slot != '1) begin
        row_bumped[j*COUNT_BITS +: COUNT_BITS] = slot + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      row    <= mem[addr];
      addr_q <= addr;
      ctl_q  <= ctl;
    end
    if (clr) begin
      mem[clr_addr] <= '0;
    end else if (commit && ctl_q.bump) begin
      mem[addr_q] <= row_bumped;
    end
  end

endmodule

>>> rtl/core/word_position_ngram_counter.sv
// Top level of the word position n-gram counter.
//
// Items arrive on the s_axis channel. A push item shifts a symbol (0 space,
// 1..LETTERS letter) into the word window and bumps unigram, bigram and
// trigram counters for word start, middle and end. A read item returns one
// counter on the m_axis channel, saturated to 32 bits. A clear item zeroes
// every counter and empties the window.
// For a push or read item the acceptance cycle reads one row from each
// counter memory, and the update state that follows writes the bumped rows
// back or, for a read, loads the result register once it is free. No new
// item is taken before that pass ends, so no two accesses to a row overlap
// and no forwarding is needed. A result waits in the output register;
// further push items are taken while it waits, and only a second read
// stalls until the receiver takes the first. After reset and after a clear
// item the block sweeps the memories, one row a cycle, through every row of
// the trigram memory, and s_axis_tready stays low during the sweep.
module word_position_ngram_counter import wngc_pkg::*; #(
  parameter int LETTERS    = LETTERS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: opcode[1:0], symbol[7:2], gram_length[9:8],
  // letter_oldest[14:10], letter_middle[19:15], letter_newest[24:20],
  // word_position[26:25], zero fill[31:27].
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: counter_value[31:0].
  output logic [31:0] m_axis_tdata
);

  `include "word_position_ngram_counter_macros.svh"

  // Bits of one letter index, and of the unigram, bigram and trigram rows.
  localparam int LW  = (LETTERS > 1) ? $clog2(LETTERS) : 1;
  localparam int AW1 = LW;
  localparam int AW2 = 2 * LW;
  localparam int AW3 = 3 * LW;

  // Input item fields.
  logic [1:0]             opcode;
  logic [SYMBOL_BITS-1:0] symbol;
  logic [1:0]             gram_length;
  logic [LETTER_BITS-1:0] letter_oldest;
  logic [LETTER_BITS-1:0] letter_middle;
  logic [LETTER_BITS-1:0] letter_newest;
  logic [1:0]             word_position;

  assign opcode        = s_axis_tdata[1:0];
  assign symbol        = s_axis_tdata[7:2];
  assign gram_length   = s_axis_tdata[9:8];
  assign letter_oldest = s_axis_tdata[14:10];
  assign letter_middle = s_axis_tdata[19:15];
  assign letter_newest = s_axis_tdata[24:20];
  assign word_position = s_axis_tdata[26:25];

  wngc_state_t state, state_next;

  // The window keeps the last four symbols, window[0] the newest; a fifth
  // symbol never decides any count.
  logic [SYMBOL_BITS-1:0] window [4];
  logic [AW3-1:0]         sweep;
  logic [1:0]             op_q;
  logic [1:0]             gram_q;
  logic [1:0]             wpos_q;
  logic                   read_ok_q;

  logic accept;
  logic issue;
  logic commit;
  logic clr_en;
  logic out_load;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Word window decode: letter flags and letter indices of the old window.
  logic [3:0]             nz;
  logic [SYMBOL_BITS-1:0] lidx [3];
  logic [SYMBOL_BITS-1:0] new_idx;
  logic                   push_ok;
  logic                   is_letter;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nz[i] = (window[i] != '0);
    end
    for (int i = 0; i < 3; i++) begin
      lidx[i] = window[i] - SYMBOL_BITS'(1);
    end
    new_idx   = symbol - SYMBOL_BITS'(1);
    push_ok   = (opcode == OP_PUSH) && ({1'b0, symbol} <= 7'(LETTERS));
    is_letter = (symbol != '0);
  end

  // Read item field checks.
  logic [SYMBOL_BITS-1:0] rd_o;
  logic [SYMBOL_BITS-1:0] rd_m;
  logic [SYMBOL_BITS-1:0] rd_n;
  logic                   read_ok;

  always_comb begin
    rd_o    = {1'b0, letter_oldest};
    rd_m    = {1'b0, letter_middle};
    rd_n    = {1'b0, letter_newest};
    read_ok = (word_position != POS_NONE) && (gram_length != 2'd0)
              && ({1'b0, rd_o} < 7'(LETTERS))
              && (gram_length == GRAM_UNI || {1'b0, rd_m} < 7'(LETTERS))
              && (gram_length != GRAM_TRI || {1'b0, rd_n} < 7'(LETTERS));
  end

  // Row addresses and bump requests for the three tables.
  logic [AW1-1:0] addr1;
  logic [AW2-1:0] addr2;
  logic [AW3-1:0] addr3;
  wngc_ctl_t      ctl1, ctl2, ctl3;

  always_comb begin
    ctl1 = '{bump: 1'b0, pos: POS_START};
    ctl2 = '{bump: 1'b0, pos: POS_START};
    ctl3 = '{bump: 1'b0, pos: POS_START};
    addr1 = lidx[0][LW-1:0];
    addr2 = {lidx[1][LW-1:0], lidx[0][LW-1:0]};
    addr3 = {lidx[2][LW-1:0], lidx[1][LW-1:0], lidx[0][LW-1:0]};
    if (opcode == OP_READ) begin
      addr1 = rd_o[LW-1:0];
      addr2 = {rd_o[LW-1:0], rd_m[LW-1:0]};
      addr3 = {rd_o[LW-1:0], rd_m[LW-1:0], rd_n[LW-1:0]};
    end else if (push_ok && !is_letter) begin
      // A space closes the word: end counters of its last one to three letters.
      ctl1 = '{bump: nz[0], pos: POS_END};
      ctl2 = '{bump: nz[0] && nz[1], pos: POS_END};
      ctl3 = '{bump: nz[0] && nz[1] && nz[2], pos: POS_END};
    end else if (push_ok) begin
      // The new letter's place in its word picks the start gram; the grams
      // ending at the previous letter with letters on both sides count as middle.
      if (!nz[0]) begin
        addr1 = new_idx[LW-1:0];
        ctl1  = '{bump: 1'b1, pos: POS_START};
      end else if (nz[1]) begin
        ctl1 = '{bump: 1'b1, pos: POS_MIDDLE};
      end
      if (nz[0] && !nz[1]) begin
        addr2 = {lidx[0][LW-1:0], new_idx[LW-1:0]};
        ctl2  = '{bump: 1'b1, pos: POS_START};
      end else if (nz[0] && nz[1] && nz[2]) begin
        ctl2 = '{bump: 1'b1, pos: POS_MIDDLE};
      end
      if (nz[0] && nz[1] && !nz[2]) begin
        addr3 = {lidx[1][LW-1:0], lidx[0][LW-1:0], new_idx[LW-1:0]};
        ctl3  = '{bump: 1'b1, pos: POS_START};
      end else if (nz[0] && nz[1] && nz[2] && nz[3]) begin
        ctl3 = '{bump: 1'b1, pos: POS_MIDDLE};
      end
    end
  end

  // Counter memories.
  logic [3*COUNT_BITS-1:0] row1, row2, row3;

  wngc_table #(.ADDR_BITS(AW1), .COUNT_BITS(COUNT_BITS)) u_uni (
    .clk(clk), .issue(issue), .addr(addr1), .ctl(ctl1), .commit(commit),
    .clr(clr_en), .clr_addr(sweep[AW1-1:0]), .row(row1)
  );

  wngc_table #(.ADDR_BITS(AW2), .COUNT_BITS(COUNT_BITS)) u_bi (
    .clk(clk), .issue(issue), .addr(addr2), .ctl(ctl2), .commit(commit),
    .clr(clr_en), .clr_addr(sweep[AW2-1:0]), .row(row2)
  );

  wngc_table #(.ADDR_BITS(AW3), .COUNT_BITS(COUNT_BITS)) u_tri (
    .clk(clk), .issue(issue), .addr(addr3), .ctl(ctl3), .commit(commit),
    .clr(clr_en), .clr_addr(sweep), .row(row3)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (opcode == OP_CLEAR) ? ST_CLEAR : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!(op_q == OP_READ && m_axis_tvalid && !m_axis_tready)) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (sweep == '1) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    clr_en        = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_UPDATE: begin
        commit   = 1'b1;
        out_load = (op_q == OP_READ) && (!m_axis_tvalid || m_axis_tready);
      end
      ST_CLEAR:  clr_en = 1'b1;
      default:   clr_en = 1'b0;
    endcase
    issue = s_axis_tvalid && s_axis_tready;
  end

  // Counter selection for a read, saturated to the 32-bit result.
  logic [3*COUNT_BITS-1:0] row_sel;
  logic [COUNT_BITS-1:0]   count_sel;
  logic [63:0]             count_ext;
  logic [OUT_BITS-1:0]     result;

  always_comb begin
    case (gram_q)
      GRAM_UNI: row_sel = row1;
      GRAM_BI:  row_sel = row2;
      GRAM_TRI: row_sel = row3;
      default:  row_sel = '0;
    endcase
    case (wpos_q)
      POS_START:  count_sel = row_sel[0 +: COUNT_BITS];
      POS_MIDDLE: count_sel = row_sel[COUNT_BITS +: COUNT_BITS];
      POS_END:    count_sel = row_sel[2*COUNT_BITS +: COUNT_BITS];
      default:    count_sel = '0;
    endcase
    count_ext = 64'(count_sel);
    if (!read_ok_q) begin
      result = '0;
    end else if (count_ext[63:32] != '0) begin
      result = '1;
    end else begin
      result = count_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      sweep         <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        window[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (clr_en) begin
        sweep <= sweep + AW3'(1);
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept && opcode == OP_CLEAR) begin
        sweep <= '0;
        for (int i = 0; i < 4; i++) begin
          window[i] <= '0;
        end
      end else if (accept && push_ok) begin
        window[0] <= symbol;
        for (int i = 1; i < 4; i++) begin
          window[i] <= window[i-1];
        end
      end
    end
  end

  // Payload registers of the item in flight and of the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= opcode;
      gram_q    <= gram_length;
      wpos_q    <= word_position;
      read_ok_q <= read_ok;
    end
    if (out_load) begin
      m_axis_tdata <= result;
    end
  end

  // A clear item starts the sweep at the first row.
  `WNGC_ASSERT_NEXT(a_clear_starts_sweep, accept && opcode == OP_CLEAR, state == ST_CLEAR && sweep == '0, "clear item did not start the memory sweep")
  // A read with a free output register delivers its result in the next cycle.
  `WNGC_ASSERT_NEXT(a_read_delivers, state == ST_UPDATE && op_q == OP_READ && !m_axis_tvalid, m_axis_tvalid, "read result was not loaded")
  // A result only appears after the update step of a read.
  `WNGC_ASSERT_NOW(a_result_source, $rose(m_axis_tvalid), $past(state) == ST_UPDATE && $past(op_q) == OP_READ, "result appeared without a read")

endmodule
